[rtl/core/kwm_pkg.sv]
package kwm_pkg;

	localparam int LIST_COUNT  = 8;
	localparam int LIST_DEPTH  = 8;
	localparam int VALUE_W     = 32;
	localparam int ID_W        = 3;
	localparam int LIST_W      = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
	localparam int TREE_N      = 1 << LIST_W;
	localparam int POS_W       = $clog2(LIST_DEPTH + 1);
	localparam int ENTRIES     = LIST_COUNT * LIST_DEPTH;
	localparam int ADDR_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int TOTAL_W     = $clog2(ENTRIES + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// command classes handed from front to back
	typedef enum logic [1:0] {
		OP_STORE     = 2'd1,
		OP_END       = 2'd2,
		OP_STORE_END = 2'd3
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic [ID_W-1:0]           list_id;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	// element store address of entry pos in list
	function automatic logic [ADDR_W-1:0] row_addr(input logic [LIST_W-1:0] list,
		input logic [POS_W-1:0] pos);
		return ADDR_W'(ADDR_W'(list) * ADDR_W'(LIST_DEPTH) + ADDR_W'(pos));
	endfunction

endpackage

[rtl/core/kwm_in_if.sv]
interface kwm_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [kwm_pkg::VALUE_W-1:0]  value;
	logic [kwm_pkg::ID_W-1:0]            list_id;
	logic                                has_value;
	logic                                end_of_set;

	modport source(output valid, value, list_id, has_value, end_of_set, input ready);
	modport sink(input valid, value, list_id, has_value, end_of_set, output ready);
endinterface

[rtl/core/kwm_out_if.sv]
interface kwm_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [kwm_pkg::VALUE_W-1:0]  merged_value;
	logic [kwm_pkg::ID_W-1:0]            source_list;
	logic                                last;
	logic                                empty_res;
	logic                                dropped;

	modport source(output valid, merged_value, source_list, last, empty_res, dropped,
		input ready);
	modport sink(input valid, merged_value, source_list, last, empty_res, dropped,
		output ready);
endinterface

[rtl/core/kwm_front.sv]
module kwm_front (
	kwm_in_if.sink          item,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output kwm_pkg::cmd_t   cmd
);

	assign item.ready = cmd_ready;

	// words with neither flag are taken and discarded
	always_comb begin
		cmd.value   = item.value;
		cmd.list_id = item.list_id;
		cmd.op      = kwm_pkg::OP_STORE;
		cmd_valid   = 1'b0;
		unique case ({item.has_value, item.end_of_set})
			2'b10: begin
				cmd.op    = kwm_pkg::OP_STORE;
				cmd_valid = item.valid;
			end
			2'b01: begin
				cmd.op    = kwm_pkg::OP_END;
				cmd_valid = item.valid;
			end
			2'b11: begin
				cmd.op    = kwm_pkg::OP_STORE_END;
				cmd_valid = item.valid;
			end
			default: begin
				cmd_valid = 1'b0;
			end
		endcase
	end

endmodule

[rtl/core/kwm_queue.sv]
module kwm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  kwm_pkg::cmd_t   push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output kwm_pkg::cmd_t   pop_data
);

	kwm_pkg::cmd_t                  slot_q [kwm_pkg::QUEUE_DEPTH];
	logic [kwm_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [kwm_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [kwm_pkg::QCNT_W-1:0]     cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = (cnt_q != kwm_pkg::QCNT_W'(kwm_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/kwm_back.sv]
module kwm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  kwm_pkg::cmd_t   cmd,
	kwm_out_if.source       result
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EMPTY = 6'b000010,
		S_LOAD  = 6'b000100,
		S_LOADW = 6'b001000,
		S_PICK  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t                                 state_q;
	logic signed [kwm_pkg::VALUE_W-1:0]     mem [kwm_pkg::ENTRIES];
	logic signed [kwm_pkg::VALUE_W-1:0]     rd_data_q;
	logic [kwm_pkg::POS_W-1:0]              fill_q [kwm_pkg::LIST_COUNT];
	logic [kwm_pkg::POS_W-1:0]              pos_q  [kwm_pkg::LIST_COUNT];
	logic signed [kwm_pkg::VALUE_W-1:0]     head_q [kwm_pkg::LIST_COUNT];
	logic                                   ovf_q;
	logic [kwm_pkg::TOTAL_W-1:0]            total_q;
	logic [kwm_pkg::LIST_W-1:0]             idx_q;
	logic                                   ld_vld_s1;
	logic [kwm_pkg::LIST_W-1:0]             ld_idx_s1;
	logic                                   wait_q;
	logic [kwm_pkg::LIST_W-1:0]             best_q;
	logic signed [kwm_pkg::VALUE_W-1:0]     bestval_q;

	logic                                   ov_q;
	logic signed [kwm_pkg::VALUE_W-1:0]     o_value_q;
	logic [kwm_pkg::ID_W-1:0]               o_src_q;
	logic                                   o_last_q;
	logic                                   o_empty_q;
	logic                                   o_drop_q;

	logic                                   pop;
	logic                                   has_store;
	logic                                   has_end;
	logic [kwm_pkg::LIST_W-1:0]             cid;
	logic                                   in_range;
	logic                                   store_ok;
	logic [kwm_pkg::TOTAL_W-1:0]            total_nx;
	logic                                   out_free;
	logic                                   emit_fire;
	logic                                   rd_en;
	logic [kwm_pkg::ADDR_W-1:0]             rd_addr;

	logic                                   nd_v   [2*kwm_pkg::TREE_N];
	logic signed [kwm_pkg::VALUE_W-1:0]     nd_val [2*kwm_pkg::TREE_N];
	logic [kwm_pkg::LIST_W-1:0]             nd_idx [2*kwm_pkg::TREE_N];

	assign cmd_ready = (state_q == S_IDLE);
	assign pop       = cmd_valid && cmd_ready;
	assign has_store = (cmd.op == kwm_pkg::OP_STORE) || (cmd.op == kwm_pkg::OP_STORE_END);
	assign has_end   = (cmd.op == kwm_pkg::OP_END) || (cmd.op == kwm_pkg::OP_STORE_END);
	assign cid       = kwm_pkg::LIST_W'(cmd.list_id);
	assign in_range  = ({1'b0, cmd.list_id} < (kwm_pkg::ID_W + 1)'(kwm_pkg::LIST_COUNT));
	assign store_ok  = pop && has_store && in_range
		&& (fill_q[cid] < kwm_pkg::POS_W'(kwm_pkg::LIST_DEPTH));
	assign total_nx  = total_q + kwm_pkg::TOTAL_W'(store_ok);
	assign out_free  = !ov_q || result.ready;
	assign emit_fire = (state_q == S_EMIT) && !wait_q && out_free;

	// min tree over list heads, lower list wins ties
	always_comb begin
		for (int i = 0; i < kwm_pkg::TREE_N; i++) begin
			if (i < kwm_pkg::LIST_COUNT) begin
				nd_v[kwm_pkg::TREE_N+i]   = (pos_q[i] < fill_q[i]);
				nd_val[kwm_pkg::TREE_N+i] = head_q[i];
			end else begin
				nd_v[kwm_pkg::TREE_N+i]   = 1'b0;
				nd_val[kwm_pkg::TREE_N+i] = '0;
			end
			nd_idx[kwm_pkg::TREE_N+i] = kwm_pkg::LIST_W'(i);
		end
		nd_v[0]   = 1'b0;
		nd_val[0] = '0;
		nd_idx[0] = '0;
		for (int k = kwm_pkg::TREE_N - 1; k >= 1; k--) begin
			if (nd_v[2*k+1] && (!nd_v[2*k] || (nd_val[2*k+1] < nd_val[2*k]))) begin
				nd_v[k]   = 1'b1;
				nd_val[k] = nd_val[2*k+1];
				nd_idx[k] = nd_idx[2*k+1];
			end else begin
				nd_v[k]   = nd_v[2*k];
				nd_val[k] = nd_val[2*k];
				nd_idx[k] = nd_idx[2*k];
			end
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = kwm_pkg::row_addr(best_q, pos_q[best_q] + 1'b1);
		if (state_q == S_LOAD) begin
			rd_en   = 1'b1;
			rd_addr = kwm_pkg::row_addr(idx_q, '0);
		end else if (emit_fire) begin
			rd_en = 1'b1;
		end
	end

	// element store: one write, one registered read
	always_ff @(posedge clk) begin
		if (store_ok) begin
			mem[kwm_pkg::row_addr(cid, fill_q[cid])] <= cmd.value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		ld_idx_s1 <= idx_q;
		if (ld_vld_s1) begin
			head_q[ld_idx_s1] <= rd_data_q;
		end else if (wait_q) begin
			head_q[best_q] <= rd_data_q;
		end
		if (state_q == S_PICK) begin
			best_q    <= nd_idx[1];
			bestval_q <= nd_val[1];
		end
		if (state_q == S_EMPTY && out_free) begin
			o_value_q <= '0;
			o_src_q   <= '0;
			o_last_q  <= 1'b1;
			o_empty_q <= 1'b1;
			o_drop_q  <= ovf_q;
		end else if (emit_fire) begin
			o_value_q <= bestval_q;
			o_src_q   <= kwm_pkg::ID_W'(best_q);
			o_last_q  <= (total_q == kwm_pkg::TOTAL_W'(1));
			o_empty_q <= 1'b0;
			o_drop_q  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ovf_q     <= 1'b0;
			total_q   <= '0;
			idx_q     <= '0;
			ld_vld_s1 <= 1'b0;
			wait_q    <= 1'b0;
			ov_q      <= 1'b0;
			for (int i = 0; i < kwm_pkg::LIST_COUNT; i++) begin
				fill_q[i] <= '0;
				pos_q[i]  <= '0;
			end
		end else begin
			ld_vld_s1 <= (state_q == S_LOAD);
			// a head refill follows each emitted word but the last
			wait_q    <= emit_fire && (total_q != kwm_pkg::TOTAL_W'(1));
			if (emit_fire || (state_q == S_EMPTY && out_free)) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (store_ok) begin
							fill_q[cid] <= fill_q[cid] + 1'b1;
						end else if (has_store) begin
							ovf_q <= 1'b1;
						end
						total_q <= total_nx;
						if (has_end) begin
							idx_q   <= '0;
							state_q <= (total_nx == '0) ? S_EMPTY : S_LOAD;
						end
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_LOAD: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == kwm_pkg::LIST_W'(kwm_pkg::LIST_COUNT - 1)) begin
						state_q <= S_LOADW;
					end
				end
				S_LOADW: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_fire) begin
						total_q <= total_q - 1'b1;
						if (total_q == kwm_pkg::TOTAL_W'(1)) begin
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
							for (int i = 0; i < kwm_pkg::LIST_COUNT; i++) begin
								fill_q[i] <= '0;
								pos_q[i]  <= '0;
							end
						end else begin
							pos_q[best_q] <= pos_q[best_q] + 1'b1;
						end
					end else if (wait_q) begin
						state_q <= S_PICK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid        = ov_q;
	assign result.merged_value = o_value_q;
	assign result.source_list  = o_src_q;
	assign result.last         = o_last_q;
	assign result.empty_res    = o_empty_q;
	assign result.dropped      = o_drop_q;

endmodule

[rtl/core/k_way_sorted_merge.sv]
// Start: with the queue empty, the first merged word follows the end word through the
//   queue, head loads, load drain, pick and emit; an empty result via the empty state.
// Throughput: one element word per cycle while the queue has room; in a merge each
//   result takes a pick, an emit and a head refill via the single store read port.
// Reset: arst_n clears all list counts, read positions, the drop flag, the queue and
//   the output valid flag at once; the element store itself is not cleared.
module k_way_sorted_merge (
	input  logic        clk,
	input  logic        arst_n,
	kwm_in_if.sink      item,
	kwm_out_if.source   result
);

	// front: classify words (store / end / both), drop no-op words
	logic             f_valid;
	logic             f_ready;
	kwm_pkg::cmd_t    f_cmd;

	// back side of the command queue
	logic             b_valid;
	logic             b_ready;
	kwm_pkg::cmd_t    b_cmd;

	kwm_front u_front (
		.item      (item),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	// short queue lets loading continue while the merge engine is busy
	kwm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_cmd)
	);

	// back: per-list store, head registers, min tree, registered output
	kwm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.result    (result)
	);

endmodule
